[rtl/q2e_pkg.sv]
// shared types, constants and the arctangent step table for the quaternion to euler block
// used by every module under rtl, depends on nothing
`default_nettype none
package q2e_pkg;

   localparam int VEC_W = 48;
   localparam int ANG_W = 36;
   localparam int SQRT_BITS = 32;

   localparam logic signed [15:0] PI_Q13      = 16'sd25736;
   localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
   localparam logic signed [ANG_W-1:0] PI_Q30 = 36'sd3373259426;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W-1:0] z;
      logic                    fix;
      logic signed [15:0]      fix_val;
   } q2e_lane_type;

   typedef struct packed {
      logic [63:0]          v;
      logic [35:0]          rem;
      logic [SQRT_BITS-1:0] root;
   } q2e_sqrt_type;

   // atan(2^-i) in q.30, rounded
   function automatic logic [31:0] atan_step(input logic [4:0] i);
      logic [31:0] r;
      unique case (i)
         5'd0:    r = 32'd843314857;
         5'd1:    r = 32'd497837829;
         5'd2:    r = 32'd263043837;
         5'd3:    r = 32'd133525159;
         5'd4:    r = 32'd67021687;
         5'd5:    r = 32'd33543516;
         5'd6:    r = 32'd16775851;
         5'd7:    r = 32'd8388437;
         5'd8:    r = 32'd4194283;
         5'd9:    r = 32'd2097149;
         5'd10:   r = 32'd1048576;
         5'd11:   r = 32'd524288;
         5'd12:   r = 32'd262144;
         5'd13:   r = 32'd131072;
         5'd14:   r = 32'd65536;
         5'd15:   r = 32'd32768;
         5'd16:   r = 32'd16384;
         5'd17:   r = 32'd8192;
         5'd18:   r = 32'd4096;
         5'd19:   r = 32'd2048;
         5'd20:   r = 32'd1024;
         5'd21:   r = 32'd512;
         5'd22:   r = 32'd256;
         5'd23:   r = 32'd128;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/q2e_sqrt_cell.sv]
// one cell of the square root row: settles one root bit per cycle
// depends on q2e_pkg
`default_nettype none
module q2e_sqrt_cell #(
   parameter int BIT = 31
) (
   input  wire                   clock,
   input  q2e_pkg::q2e_sqrt_type d_i,
   output q2e_pkg::q2e_sqrt_type d_o
);

   q2e_pkg::q2e_sqrt_type q_ff, q_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;

   always_comb begin
      rem_sh = {d_i.rem[33:0], d_i.v[2*BIT+1 -: 2]};
      trial  = {2'b00, d_i.root, 2'b01};
      q_in.v = d_i.v;
      if (rem_sh >= trial) begin
         q_in.rem  = rem_sh - trial;
         q_in.root = {d_i.root[q2e_pkg::SQRT_BITS-2:0], 1'b1};
      end else begin
         q_in.rem  = rem_sh;
         q_in.root = {d_i.root[q2e_pkg::SQRT_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign d_o = q_ff;

endmodule
`default_nettype wire

[rtl/q2e_norm_cell.sv]
// one cell of the normalizing row: doubles a vector SHIFT times if both parts are below 2^LIMIT in magnitude
// depends on q2e_pkg
`default_nettype none
module q2e_norm_cell #(
   parameter int SHIFT = 1,
   parameter int LIMIT = 40
) (
   input  wire                   clock,
   input  q2e_pkg::q2e_lane_type d_i,
   output q2e_pkg::q2e_lane_type d_o
);

   q2e_pkg::q2e_lane_type q_ff, q_in;
   logic [q2e_pkg::VEC_W-1:0] ax;
   logic [q2e_pkg::VEC_W-1:0] ay;

   always_comb begin
      ax   = d_i.x[q2e_pkg::VEC_W-1] ? q2e_pkg::VEC_W'(-d_i.x) : q2e_pkg::VEC_W'(d_i.x);
      ay   = d_i.y[q2e_pkg::VEC_W-1] ? q2e_pkg::VEC_W'(-d_i.y) : q2e_pkg::VEC_W'(d_i.y);
      q_in = d_i;
      if ((ax >> LIMIT) == '0 && (ay >> LIMIT) == '0) begin
         q_in.x = d_i.x <<< SHIFT;
         q_in.y = d_i.y <<< SHIFT;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign d_o = q_ff;

endmodule
`default_nettype wire

[rtl/q2e_cordic_cell.sv]
// one vectoring rotation of the arctangent row
// depends on q2e_pkg for the step table
`default_nettype none
module q2e_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire                   clock,
   input  q2e_pkg::q2e_lane_type d_i,
   output q2e_pkg::q2e_lane_type d_o
);

   q2e_pkg::q2e_lane_type q_ff, q_in;
   logic signed [q2e_pkg::VEC_W-1:0] xs;
   logic signed [q2e_pkg::VEC_W-1:0] ys;
   logic signed [q2e_pkg::ANG_W-1:0] ang;

   always_comb begin
      xs   = d_i.x >>> STEP;
      ys   = d_i.y >>> STEP;
      ang  = signed'({4'b0000, q2e_pkg::atan_step(5'(STEP))});
      q_in = d_i;
      if (!d_i.y[q2e_pkg::VEC_W-1]) begin
         q_in.x = d_i.x + ys;
         q_in.y = d_i.y - xs;
         q_in.z = d_i.z + ang;
      end else begin
         q_in.x = d_i.x - ys;
         q_in.y = d_i.y + xs;
         q_in.z = d_i.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign d_o = q_ff;

endmodule
`default_nettype wire

[rtl/quaternion_to_euler.sv]
// top level: quaternion (q1.14) to roll and yaw (q2.13) and pitch (q1.13) angles
// depends on q2e_pkg, q2e_sqrt_cell, q2e_norm_cell and q2e_cordic_cell
//
// usage
//   an item is taken at each rising edge with start high and busy low; busy is
//   always low, so one quaternion can enter every cycle
//   each result is shown for exactly one cycle with rsp_valid high, in order
//   the pipeline is an input register, the products, the matrix entries, the squared
//   term and its difference, 32 cells of the square root row (one root bit each),
//   a quadrant setup register, seven normalizing cells, one cordic cell per iteration
//   and the output register
//   throughput is one item per cycle
//   reset clears the valid row only; items in flight are dropped
//   the receiver cannot hold results off, so nothing ever waits inside
`default_nettype none
module quaternion_to_euler #(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   output logic              busy,
   input  wire signed [15:0] req_q_scalar,
   input  wire signed [15:0] req_q_vec_x,
   input  wire signed [15:0] req_q_vec_y,
   input  wire signed [15:0] req_q_vec_z,
   output logic              rsp_valid,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [14:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle
);

   localparam int SQRT_STAGES = q2e_pkg::SQRT_BITS;
   localparam int NORM_STAGES = 7;
   localparam int LANE_STAGES = NORM_STAGES + ANGLE_ITERATIONS;
   localparam int LAT = 5 + SQRT_STAGES + 1 + LANE_STAGES + 1;

   typedef struct packed {
      logic signed [35:0] m11;
      logic signed [35:0] m21;
      logic signed [35:0] m32;
      logic signed [35:0] m33;
      logic signed [32:0] s;
   } side_type;

   function automatic q2e_pkg::q2e_lane_type lane_prep(input logic signed [35:0] y,
                                                       input logic signed [35:0] x);
      q2e_pkg::q2e_lane_type r;
      r.x = q2e_pkg::VEC_W'(x);
      r.y = q2e_pkg::VEC_W'(y);
      r.z = '0;
      r.fix = 1'b0;
      r.fix_val = '0;
      if (x == '0) begin
         r.fix = 1'b1;
         if (y > 0) r.fix_val = q2e_pkg::HALF_PI_Q13;
         else if (y < 0) r.fix_val = -q2e_pkg::HALF_PI_Q13;
      end else if (x < 0) begin
         r.z = (y >= 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
         r.x = -q2e_pkg::VEC_W'(x);
         r.y = -q2e_pkg::VEC_W'(y);
      end
      return r;
   endfunction

   logic [LAT-1:0] vld_ff, vld_in;

   logic signed [15:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [31:0] p_bb_ff, p_cc_ff, p_dd_ff, p_bc_ff, p_ad_ff;
   logic signed [31:0] p_cd_ff, p_ab_ff, p_bd_ff, p_ac_ff;
   side_type           side_ff [SQRT_STAGES+3];
   side_type           side_in;
   logic [31:0]        s_mag;
   logic [63:0]        sq_ff;
   logic [63:0]        diff_ff, diff_in;

   q2e_pkg::q2e_sqrt_type sq_d [SQRT_STAGES+1];
   q2e_pkg::q2e_lane_type prep_ff [3];
   q2e_pkg::q2e_lane_type prep_in [3];
   q2e_pkg::q2e_lane_type lane_d [3][LANE_STAGES+1];
   logic signed [15:0]    ang_out [3];

   logic signed [15:0] roll_ff, yaw_ff;
   logic signed [14:0] pitch_ff;

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      side_in.m11 = 36'sh010000000 - ((36'(p_cc_ff) + 36'(p_dd_ff)) <<< 1);
      side_in.m21 = (36'(p_bc_ff) + 36'(p_ad_ff)) <<< 1;
      side_in.m32 = (36'(p_cd_ff) + 36'(p_ab_ff)) <<< 1;
      side_in.m33 = 36'sh010000000 - ((36'(p_bb_ff) + 36'(p_cc_ff)) <<< 1);
      side_in.s   = 33'(p_bd_ff) - 33'(p_ac_ff);
      s_mag = side_ff[0].s[32] ? 32'(-side_ff[0].s) : 32'(side_ff[0].s);
      diff_in = (sq_ff >= 64'h0040_0000_0000_0000) ? sq_ff - 64'h0040_0000_0000_0000
                                                   : 64'h0040_0000_0000_0000 - sq_ff;
   end

   always_ff @(posedge clock) begin
      a_ff <= req_q_scalar;
      b_ff <= req_q_vec_x;
      c_ff <= req_q_vec_y;
      d_ff <= req_q_vec_z;
      p_bb_ff <= b_ff * b_ff;
      p_cc_ff <= c_ff * c_ff;
      p_dd_ff <= d_ff * d_ff;
      p_bc_ff <= b_ff * c_ff;
      p_ad_ff <= a_ff * d_ff;
      p_cd_ff <= c_ff * d_ff;
      p_ab_ff <= a_ff * b_ff;
      p_bd_ff <= b_ff * d_ff;
      p_ac_ff <= a_ff * c_ff;
      side_ff[0] <= side_in;
      sq_ff      <= s_mag * s_mag;
      diff_ff    <= diff_in;
      for (int k = 1; k < SQRT_STAGES + 3; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   assign sq_d[0] = '{v: diff_ff, rem: '0, root: '0};

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      q2e_sqrt_cell #(.BIT(SQRT_STAGES - 1 - k)) u_cell (
         .clock(clock),
         .d_i  (sq_d[k]),
         .d_o  (sq_d[k+1])
      );
   end

   always_comb begin
      prep_in[0] = lane_prep(side_ff[SQRT_STAGES+2].m32, side_ff[SQRT_STAGES+2].m33);
      prep_in[1] = lane_prep(-36'(side_ff[SQRT_STAGES+2].s),
                             36'(sq_d[SQRT_STAGES].root));
      prep_in[2] = lane_prep(side_ff[SQRT_STAGES+2].m21, side_ff[SQRT_STAGES+2].m11);
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         prep_ff[l] <= prep_in[l];
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [35:0] rnd;
      logic signed [35:0] lim;

      assign lane_d[l][0] = prep_ff[l];

      for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
         localparam int SH = (j < NORM_STAGES - 1) ? (32 >> j) : 1;
         localparam int LM = (j < NORM_STAGES - 1) ? 40 - (32 >> j) : 40;
         q2e_norm_cell #(.SHIFT(SH), .LIMIT(LM)) u_cell (
            .clock(clock),
            .d_i  (lane_d[l][j]),
            .d_o  (lane_d[l][j+1])
         );
      end

      for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
         q2e_cordic_cell #(.STEP(i)) u_cell (
            .clock(clock),
            .d_i  (lane_d[l][NORM_STAGES+i]),
            .d_o  (lane_d[l][NORM_STAGES+i+1])
         );
      end

      always_comb begin
         rnd = (lane_d[l][LANE_STAGES].z + 36'sd65536) >>> 17;
         lim = (l == 1) ? 36'(q2e_pkg::HALF_PI_Q13) : 36'(q2e_pkg::PI_Q13);
         if (lane_d[l][LANE_STAGES].fix) begin
            ang_out[l] = lane_d[l][LANE_STAGES].fix_val;
         end else if (rnd > lim) begin
            ang_out[l] = 16'(lim);
         end else if (rnd < -lim) begin
            ang_out[l] = 16'(-lim);
         end else begin
            ang_out[l] = 16'(rnd);
         end
      end
   end

   always_ff @(posedge clock) begin
      roll_ff  <= ang_out[0];
      pitch_ff <= 15'(ang_out[1]);
      yaw_ff   <= ang_out[2];
   end

   assign rsp_valid       = vld_ff[LAT-1];
   assign rsp_roll_angle  = roll_ff;
   assign rsp_pitch_angle = pitch_ff;
   assign rsp_yaw_angle   = yaw_ff;

endmodule
`default_nettype wire

[test/testbench.sv]
// self-checking testbench for quaternion_to_euler: random and corner quaternions in,
// roll, pitch and yaw compared against an in-bench cordic angle predictor
// depends on rtl/quaternion_to_euler.sv and, through it, on rtl/q2e_pkg.sv and the cell files
`timescale 1ns / 1ps
module testbench;

   localparam int ITERS = 16;
   localparam int LATENCY = 46 + ITERS;
   localparam int N_RANDOM = 1400;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint PI_ACC = 64'sd3373259426;
   localparam longint NORM_LEVEL = 64'sd1 << 40;

   typedef struct packed {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
      logic signed [15:0] d;
   } quat_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
   } angles_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [15:0] req_q_scalar = 0, req_q_vec_x = 0, req_q_vec_y = 0, req_q_vec_z = 0;
   logic rsp_valid;
   logic signed [15:0] rsp_roll_angle, rsp_yaw_angle;
   logic signed [14:0] rsp_pitch_angle;

   quat_type pending_quats[$];
   angles_type expected_angles[$];
   int send_idle_pct = 0;
   int mismatches = 0;
   int angles_checked = 0;
   int quats_sent = 0;
   longint cycle_count = 0;

   quaternion_to_euler #(.ANGLE_ITERATIONS(ITERS)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_q_scalar(req_q_scalar), .req_q_vec_x(req_q_vec_x),
      .req_q_vec_y(req_q_vec_y), .req_q_vec_z(req_q_vec_z),
      .rsp_valid(rsp_valid), .rsp_roll_angle(rsp_roll_angle),
      .rsp_pitch_angle(rsp_pitch_angle), .rsp_yaw_angle(rsp_yaw_angle)
   );

   always #5 clock = ~clock;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint arc_step(int i);
      longint sum, term;
      if (i == 0) return 64'sd843314857;
      sum = 0;
      for (int k = 0; i * (2 * k + 1) < 61; k++) begin
         term = longint'((64'd1 << 60) >> (i * (2 * k + 1))) / (2 * k + 1);
         sum += (k % 2) ? -term : term;
      end
      return (sum + (64'sd1 << 29)) >>> 30;
   endfunction

   function automatic longint clamp_angle(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic longint four_quadrant_atan(longint y, longint x);
      longint off, z, m, ay, xs, ys;
      off = 0;
      z = 0;
      if (x == 0) return (y > 0) ? 12868 : (y < 0) ? -12868 : 0;
      if (x < 0) begin
         off = (y >= 0) ? PI_ACC : -PI_ACC;
         x = -x;
         y = -y;
      end
      ay = (y < 0) ? -y : y;
      m = (x > ay) ? x : ay;
      while (m < NORM_LEVEL) begin
         x *= 2;
         y *= 2;
         m *= 2;
      end
      for (int i = 0; i < ITERS; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x += ys;
            y -= xs;
            z += arc_step(i);
         end else begin
            x -= ys;
            y += xs;
            z -= arc_step(i);
         end
      end
      return clamp_angle(floor_shift(off + z + (64'sd1 << 16), 17), 25736);
   endfunction

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic angles_type euler_from_quat(quat_type q);
      longint a, b, c, d, m11, m21, m32, m33, s, pitch;
      longint unsigned s2, diff, r;
      angles_type e;
      a = q.a;
      b = q.b;
      c = q.c;
      d = q.d;
      m11 = (64'sd1 << 28) - 2 * (c * c + d * d);
      m21 = 2 * (b * c + a * d);
      m32 = 2 * (c * d + a * b);
      m33 = (64'sd1 << 28) - 2 * (b * b + c * c);
      s = b * d - a * c;
      s2 = longint'(s * s);
      diff = (s2 >= (64'd1 << 54)) ? s2 - (64'd1 << 54) : (64'd1 << 54) - s2;
      r = floor_root(diff);
      if (r == 0) pitch = (s < 0) ? 12868 : (s > 0) ? -12868 : 0;
      else pitch = clamp_angle(four_quadrant_atan(-s, longint'(r)), 12868);
      e.roll = 16'(four_quadrant_atan(m32, m33));
      e.pitch = 15'(pitch);
      e.yaw = 16'(four_quadrant_atan(m21, m11));
      return e;
   endfunction

   function automatic logic signed [15:0] rand_comp(int mode);
      case (mode)
         0: return 16'($signed($urandom_range(32768)) - 16384);
         1: return 16'($urandom);
         default: return 16'($signed($urandom_range(64)) - 32);
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      quat_type q;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         start <= 0;
      end else begin
         if (start && !busy) quats_sent <= quats_sent + 1;
         if ((!start || !busy) && pending_quats.size() > 0
               && $urandom_range(99) >= send_idle_pct) begin
            q = pending_quats.pop_front();
            expected_angles.push_back(euler_from_quat(q));
            req_q_scalar <= q.a;
            req_q_vec_x <= q.b;
            req_q_vec_y <= q.c;
            req_q_vec_z <= q.d;
            start <= 1;
         end else if (!start || !busy) begin
            start <= 0;
            req_q_scalar <= 16'($urandom);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      angles_type e;
      if (!reset && rsp_valid) begin
         if (expected_angles.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycle_count);
         end else begin
            e = expected_angles.pop_front();
            angles_checked++;
            if (e.roll !== rsp_roll_angle || e.pitch !== rsp_pitch_angle
                  || e.yaw !== rsp_yaw_angle) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected r/p/y %0d %0d %0d got %0d %0d %0d",
                           e.roll, e.pitch, e.yaw, rsp_roll_angle, rsp_pitch_angle,
                           rsp_yaw_angle);
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      quat_type q;
      int mode;
      logic signed [15:0] corner[6];
      corner = '{16384, -16384, 0, 11585, -11585, 16'sh7fff};
      repeat (5) @(posedge clock);
      reset <= 0;
      // directed: identity, axis flips, gimbal lock, extremes
      pending_quats.push_back('{16384, 0, 0, 0});
      pending_quats.push_back('{0, 16384, 0, 0});
      pending_quats.push_back('{0, 0, 16384, 0});
      pending_quats.push_back('{0, 0, 0, 16384});
      pending_quats.push_back('{11585, 0, 11585, 0});
      pending_quats.push_back('{11585, 0, -11585, 0});
      pending_quats.push_back('{8192, 8192, 8192, -8192});
      pending_quats.push_back('{8192, -8192, 8192, 8192});
      pending_quats.push_back('{0, 0, 0, 0});
      pending_quats.push_back('{-16384, 0, 0, 0});
      pending_quats.push_back('{-32768, -32768, -32768, -32768});
      pending_quats.push_back('{32767, 32767, 32767, 32767});
      pending_quats.push_back('{32767, -32768, 32767, -32768});
      pending_quats.push_back('{16384, 16384, 16384, 16384});
      pending_quats.push_back('{0, 11585, 0, 11585});
      pending_quats.push_back('{-11585, 0, 0, 11585});
      pending_quats.push_back('{-11585, 0, 0, -11585});
      for (int i = 0; i < 6; i++)
         pending_quats.push_back('{corner[$urandom_range(5)], corner[$urandom_range(5)],
                                   corner[$urandom_range(5)], corner[i]});
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1) ? 46 : (ph == 3) ? 33 : 0;
         for (int i = 0; i < N_RANDOM / 4; i++) begin
            mode = $urandom_range(9);
            if (mode < 7) q = '{rand_comp(0), rand_comp(0), rand_comp(0), rand_comp(0)};
            else if (mode == 7)
               q = '{rand_comp(1), rand_comp(1), rand_comp(1), rand_comp(1)};
            else if (mode == 8)
               q = '{rand_comp(2), rand_comp(2), rand_comp(2), rand_comp(2)};
            else
               q = '{corner[$urandom_range(5)], rand_comp(2), corner[$urandom_range(5)],
                     rand_comp(0)};
            pending_quats.push_back(q);
         end
         while (pending_quats.size() > 0) @(posedge clock);
      end
      while (expected_angles.size() > 0 || start) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("sent %0d quaternions, checked %0d angle sets, %0d mismatches",
               quats_sent, angles_checked, mismatches);
      if (mismatches == 0 && expected_angles.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
